// ===== rtl/lspe_pkg.sv =====
// shared types and codes for the lsb stego payload extractor
// no dependencies; imported by every module of the block
`default_nettype none

package lspe_pkg;

    localparam int HEADER_BYTES_DEF = 54;
    localparam int EXT_MAX_DEF      = 4;

    // result queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic CFG_MAGIC_CHARS = 1'b0;
    localparam logic CFG_MAGIC_LEN   = 1'b1;

    // parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_MAGIC  = 3'd1;
    localparam logic [2:0] PH_EXTLEN = 3'd2;
    localparam logic [2:0] PH_EXT    = 3'd3;
    localparam logic [2:0] PH_SIZE   = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_HALT   = 3'd6;

    // result kinds
    localparam logic [2:0] KIND_EXT_CHAR  = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
    localparam logic [2:0] KIND_MAGIC_ERR = 3'd2;
    localparam logic [2:0] KIND_EXT_LONG  = 3'd3;
    localparam logic [2:0] KIND_EMPTY     = 3'd4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/lspe_parse.sv =====
// front end: header skip, lsb gathering and file format parsing
// depends on lspe_pkg; pushes one result per accepted byte at most
`default_nettype none

module lspe_parse #(
    parameter int HEADER_BYTES = lspe_pkg::HEADER_BYTES_DEF,
    parameter int EXT_MAX      = lspe_pkg::EXT_MAX_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [31:0]      i_cfg_data,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_image_byte,
    input  wire logic             i_file_start,
    output logic                  o_res_valid,
    output lspe_pkg::t_result     o_res
);
    import lspe_pkg::*;

    localparam logic [2:0] START_PHASE = (HEADER_BYTES == 0) ? PH_MAGIC : PH_HEADER;

    logic [31:0] r_magic_chars;
    logic [2:0]  r_magic_len;

    logic [2:0]  r_phase,   n_phase,   cur_phase;
    logic [5:0]  r_hdr_cnt, n_hdr_cnt, cur_hdr_cnt;
    logic [4:0]  r_bit_idx, n_bit_idx, cur_bit_idx;
    logic [31:0] r_gather,  n_gather,  cur_gather;
    logic [2:0]  r_item,    n_item,    cur_item;
    logic [2:0]  r_ext_len, n_ext_len, cur_ext_len;
    logic [31:0] r_left,    n_left,    cur_left;

    logic [31:0] gathered;
    logic        wide, word_done;
    logic [2:0]  eff_magic_len;
    logic [7:0]  expect_char;
    logic [3:0]  item_inc;
    logic [31:0] left_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_chars <= '0;
            r_magic_len   <= 3'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC_CHARS: r_magic_chars <= i_cfg_data;
                CFG_MAGIC_LEN:   r_magic_len   <= i_cfg_data[2:0];
                default:         r_magic_len   <= r_magic_len;
            endcase
        end
    end

    always_comb begin
        // a file start restarts parsing on this very byte
        cur_phase   = i_file_start ? START_PHASE : r_phase;
        cur_hdr_cnt = i_file_start ? '0 : r_hdr_cnt;
        cur_bit_idx = i_file_start ? '0 : r_bit_idx;
        cur_gather  = i_file_start ? '0 : r_gather;
        cur_item    = i_file_start ? '0 : r_item;
        cur_ext_len = i_file_start ? '0 : r_ext_len;
        cur_left    = i_file_start ? '0 : r_left;

        eff_magic_len = (r_magic_len == 3'd0) ? 3'd1 :
                        (r_magic_len > 3'd4)  ? 3'd4 : r_magic_len;
        expect_char   = r_magic_chars[{cur_item[1:0], 3'b000} +: 8];
        item_inc      = {1'b0, cur_item} + 4'd1;
        left_dec      = cur_left - 32'd1;

        wide      = (cur_phase == PH_EXTLEN) || (cur_phase == PH_SIZE);
        gathered  = cur_gather | (32'(i_image_byte[0]) << cur_bit_idx);
        word_done = (cur_bit_idx == (wide ? 5'd31 : 5'd7));

        n_phase   = cur_phase;
        n_hdr_cnt = cur_hdr_cnt;
        n_bit_idx = cur_bit_idx;
        n_gather  = cur_gather;
        n_item    = cur_item;
        n_ext_len = cur_ext_len;
        n_left    = cur_left;

        o_res_valid    = 1'b0;
        o_res.out_byte = gathered[7:0];
        o_res.kind     = KIND_PAYLOAD;
        o_res.last     = 1'b0;

        if (cur_phase == PH_HEADER) begin
            n_hdr_cnt = cur_hdr_cnt + 6'd1;
            if (n_hdr_cnt == 6'(HEADER_BYTES)) begin
                n_phase = PH_MAGIC;
            end
        end else if (cur_phase >= PH_MAGIC && cur_phase <= PH_DATA) begin
            if (!word_done) begin
                n_bit_idx = cur_bit_idx + 5'd1;
                n_gather  = gathered;
            end else begin
                n_bit_idx = '0;
                n_gather  = '0;
                case (cur_phase)
                    PH_MAGIC: begin
                        if (gathered != {24'd0, expect_char}) begin
                            n_phase        = PH_HALT;
                            o_res_valid    = 1'b1;
                            o_res.out_byte = '0;
                            o_res.kind     = KIND_MAGIC_ERR;
                            o_res.last     = 1'b1;
                        end else if (item_inc >= {1'b0, eff_magic_len}) begin
                            n_item  = '0;
                            n_phase = PH_EXTLEN;
                        end else begin
                            n_item = item_inc[2:0];
                        end
                    end
                    PH_EXTLEN: begin
                        if (gathered > 32'(EXT_MAX)) begin
                            n_phase        = PH_HALT;
                            o_res_valid    = 1'b1;
                            o_res.out_byte = '0;
                            o_res.kind     = KIND_EXT_LONG;
                            o_res.last     = 1'b1;
                        end else begin
                            n_ext_len = gathered[2:0];
                            n_item    = '0;
                            n_phase   = (gathered[2:0] == 3'd0) ? PH_SIZE : PH_EXT;
                        end
                    end
                    PH_EXT: begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_EXT_CHAR;
                        if (item_inc >= {1'b0, cur_ext_len}) begin
                            n_item  = '0;
                            n_phase = PH_SIZE;
                        end else begin
                            n_item = item_inc[2:0];
                        end
                    end
                    PH_SIZE: begin
                        n_left = gathered;
                        if (gathered == 32'd0) begin
                            n_phase        = PH_HALT;
                            o_res_valid    = 1'b1;
                            o_res.out_byte = '0;
                            o_res.kind     = KIND_EMPTY;
                            o_res.last     = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    default: begin
                        n_left      = left_dec;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_PAYLOAD;
                        if (left_dec == 32'd0) begin
                            n_phase    = PH_HALT;
                            o_res.last = 1'b1;
                        end
                    end
                endcase
            end
        end
        // halted and unused phase codes ignore the byte

        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= START_PHASE;
            r_hdr_cnt <= '0;
            r_bit_idx <= '0;
            r_gather  <= '0;
            r_item    <= '0;
            r_ext_len <= '0;
            r_left    <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_bit_idx <= n_bit_idx;
            r_gather  <= n_gather;
            r_item    <= n_item;
            r_ext_len <= n_ext_len;
            r_left    <= n_left;
        end
    end

    // every terminating kind closes the stream
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.kind == KIND_MAGIC_ERR || o_res.kind == KIND_EXT_LONG ||
                        o_res.kind == KIND_EMPTY) |-> o_res.last)
        else $error("terminating result without last");

    // a last result always leaves the parser halted
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |=> r_phase == PH_HALT)
        else $error("parser not halted after last result");

    // bit index stays within the width of the current word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MAGIC || r_phase == PH_EXT || r_phase == PH_DATA) |->
            r_bit_idx < 5'd8)
        else $error("bit index beyond byte width");

endmodule

`default_nettype wire

// ===== rtl/lspe_fifo.sv =====
// short result queue between the parser and the output stage
// depends on lspe_pkg for the result type and depth
`default_nettype none

module lspe_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lspe_pkg::t_result i_wr_data,
    input  wire logic             i_pop,
    output lspe_pkg::t_result     o_rd_data,
    output logic                  o_empty,
    output logic                  o_full
);
    import lspe_pkg::*;

    t_result              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]    r_count;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("queue push when full or pop when empty");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + QCNT_W'(1))
        else $error("queue count did not follow push");

endmodule

`default_nettype wire

// ===== rtl/lspe_out.sv =====
// back end: output register that drives the master stream
// depends on lspe_pkg; pulls results from the queue
`default_nettype none

module lspe_out (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_empty,
    input  wire lspe_pkg::t_result i_q_data,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output lspe_pkg::t_result     o_res
);
    import lspe_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    load;

    // register is free when empty or being drained this cycle
    assign load    = !r_valid || i_ready;
    assign o_q_pop = load && !i_q_empty;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= i_q_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_valid)
        else $error("popped result not presented");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && r_res == $past(r_res))
        else $error("stalled result lost");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> !(r_valid && i_ready))
        else $error("transfer without valid result");

endmodule

`default_nettype wire

// ===== rtl/lsb_stego_payload_extractor_unit.sv =====
// lsb stego payload extractor: one carrier byte per cycle in, decoded bytes out
// a result is queued when its byte is accepted, then moved to the output register
// throughput: one image byte per cycle; the parser steps on every accepted byte
// s_tready drops only when the 4-entry result queue is full
// reset (synchronous, active low) clears parser state, queue and config to defaults
// depends on lspe_pkg, lspe_parse, lspe_fifo, lspe_out
`default_nettype none

module lsb_stego_payload_extractor_unit #(
    parameter int HEADER_BYTES = lspe_pkg::HEADER_BYTES_DEF,
    parameter int EXT_MAX      = lspe_pkg::EXT_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] image_byte
    input  wire logic        s_tuser,   // [0] file_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [2:0]       m_tuser,   // [2:0] kind
    output logic             m_tlast
);
    import lspe_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res, q_data, out_res;
    logic    q_empty, q_full, q_pop;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    lspe_parse #(
        .HEADER_BYTES(HEADER_BYTES),
        .EXT_MAX     (EXT_MAX)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_image_byte(s_tdata),
        .i_file_start(s_tuser),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lspe_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_valid),
        .i_wr_data(res),
        .i_pop    (q_pop),
        .o_rd_data(q_data),
        .o_empty  (q_empty),
        .o_full   (q_full)
    );

    lspe_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_q_data (q_data),
        .o_q_pop  (q_pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_res    (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// testbench for lsb_stego_payload_extractor_unit: carrier files come from a table and at random,
// every accepted byte goes through a local decoder whose results are compared in order
// depends on lspe_pkg and the rtl of the unit

module tb;
    import lspe_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_PRINTS    = 40;
    localparam int DIR_ROWS      = 14;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       fixed;
        logic [2:0] fkind;
    } t_byte_req;

    // one carrier file: what gets hidden in it and how much of it is sent
    typedef struct packed {
        logic        wr_cfg;
        logic [31:0] cfg_chars;
        logic [2:0]  cfg_len;
        logic [31:0] magic;
        logic [2:0]  n_magic;
        logic [31:0] ext_field;
        logic [2:0]  n_ext;
        logic [31:0] pay_field;
        logic [7:0]  n_pay;
        logic [7:0]  n_tail;
        logic [15:0] cut;
        logic        fixed;
        logic [2:0]  fixed_kind;
    } t_file;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] image_byte
    logic        s_tuser;   // [0] file_start
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic [2:0]  m_tuser;   // [2:0] kind
    logic        m_tlast;

    // decoder copy of the block
    logic [31:0] magic_word;
    logic [2:0]  magic_sel;
    logic [2:0]  ph;
    int          hdr_cnt;
    int          bit_pos;
    logic [31:0] acc;
    logic [2:0]  char_cnt;
    logic [2:0]  ext_len;
    logic [31:0] remain;

    t_result     decoded_q[$];
    t_byte_req   carrier_q[$];
    t_file       dir_tab[DIR_ROWS];
    t_result     want_res;
    logic        cur_fixed;
    logic [2:0]  cur_fkind;
    logic        hold_req;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          decoded_cnt = 0;
    int          lsb_bytes   = 0;
    int          mismatch_cnt = 0;
    int          res_seen    = 0;
    int          cycle_cnt   = 0;

    lsb_stego_payload_extractor_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [2:0] magic_count(input logic [2:0] n);
        if (n == 3'd0) return 3'd1;
        if (n > 3'd4) return 3'd4;
        return n;
    endfunction

    task automatic restart_parse();
        ph       = (HEADER_BYTES_DEF == 0) ? PH_MAGIC : PH_HEADER;
        hdr_cnt  = 0;
        bit_pos  = 0;
        acc      = '0;
        char_cnt = '0;
        ext_len  = '0;
        remain   = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start,
                               output logic hit, output t_result res);
        int          width;
        logic [31:0] word;
        hit = 1'b0;
        res = '0;
        if (start) restart_parse();
        if (ph == PH_HEADER) begin
            hdr_cnt = (hdr_cnt + 1) & 63;
            if (hdr_cnt == HEADER_BYTES_DEF) ph = PH_MAGIC;
        end else if (ph >= PH_MAGIC && ph <= PH_DATA) begin
            lsb_bytes++;
            width = (ph == PH_EXTLEN || ph == PH_SIZE) ? 32 : 8;
            acc[bit_pos] = b[0];
            if (bit_pos + 1 < width) begin
                bit_pos++;
            end else begin
                word    = acc;
                bit_pos = 0;
                acc     = '0;
                case (ph)
                    PH_MAGIC: begin
                        if (word[7:0] != magic_word[8 * char_cnt[1:0] +: 8]) begin
                            ph  = PH_HALT;
                            hit = 1'b1;
                            res = {8'h00, KIND_MAGIC_ERR, 1'b1};
                        end else begin
                            char_cnt = char_cnt + 3'd1;
                            if (char_cnt >= magic_count(magic_sel)) begin
                                char_cnt = '0;
                                ph       = PH_EXTLEN;
                            end
                        end
                    end
                    PH_EXTLEN: begin
                        if (word > EXT_MAX_DEF) begin
                            ph  = PH_HALT;
                            hit = 1'b1;
                            res = {8'h00, KIND_EXT_LONG, 1'b1};
                        end else begin
                            ext_len  = word[2:0];
                            char_cnt = '0;
                            ph       = (word[2:0] == 3'd0) ? PH_SIZE : PH_EXT;
                        end
                    end
                    PH_EXT: begin
                        char_cnt = char_cnt + 3'd1;
                        if (char_cnt >= ext_len) begin
                            char_cnt = '0;
                            ph       = PH_SIZE;
                        end
                        hit = 1'b1;
                        res = {word[7:0], KIND_EXT_CHAR, 1'b0};
                    end
                    PH_SIZE: begin
                        remain = word;
                        if (word == 32'd0) begin
                            ph  = PH_HALT;
                            hit = 1'b1;
                            res = {8'h00, KIND_EMPTY, 1'b1};
                        end else begin
                            ph = PH_DATA;
                        end
                    end
                    default: begin
                        remain = remain - 32'd1;
                        hit    = 1'b1;
                        res    = {word[7:0], KIND_PAYLOAD, remain == 32'd0};
                        if (remain == 32'd0) ph = PH_HALT;
                    end
                endcase
            end
        end
    endtask

    task automatic put_byte(input logic [7:0] v);
        t_byte_req r;
        r.data  = v;
        r.start = (carrier_q.size() == 0);
        r.fixed = cur_fixed;
        r.fkind = cur_fkind;
        carrier_q.push_back(r);
    endtask

    // hide nbits of v in the lsbs of fresh carrier bytes, lsb first
    task automatic put_bits(input logic [31:0] v, input int nbits);
        logic [7:0] rb;
        int         i;
        for (i = 0; i < nbits; i++) begin
            rb    = 8'($urandom);
            rb[0] = v[i];
            put_byte(rb);
        end
    endtask

    task automatic send_req(input t_byte_req r);
        logic    hit;
        t_result res;
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.data;
        s_tuser  <= r.start;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        decode_byte(r.data, r.start, hit, res);
        if (hit) begin
            if (r.fixed) res = {8'h00, r.fkind, 1'b1};
            decoded_q.push_back(res);
            decoded_cnt++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_file(input t_file f);
        int        k;
        t_byte_req r;
        cur_fixed = f.fixed;
        cur_fkind = f.fixed_kind;
        for (k = 0; k < HEADER_BYTES_DEF; k++) put_byte(8'($urandom));
        for (k = 0; k < f.n_magic; k++) put_bits(f.magic >> (8 * k), 8);
        put_bits(f.ext_field, 32);
        for (k = 0; k < f.n_ext; k++) put_bits($urandom, 8);
        put_bits(f.pay_field, 32);
        for (k = 0; k < f.n_pay; k++)
            put_bits((k == 0) ? 32'h00 : (k == 1) ? 32'hFF : $urandom, 8);
        for (k = 0; k < f.n_tail; k++) put_byte(8'($urandom));
        if (f.cut != 0)
            while (carrier_q.size() > f.cut) r = carrier_q.pop_back();
        while (carrier_q.size() != 0) begin
            r = carrier_q.pop_front();
            send_req(r);
        end
    endtask

    task automatic rand_file(output t_file f);
        int roll;
        int nm;
        roll        = $urandom_range(99, 0);
        nm          = int'(magic_count(magic_sel));
        f           = '0;
        f.magic     = magic_word;
        f.n_magic   = 3'(nm);
        f.ext_field = $urandom_range(4, 0);
        f.n_ext     = f.ext_field[2:0];
        f.pay_field = $urandom_range(12, 1);
        f.n_pay     = f.pay_field[7:0];
        f.n_tail    = 8'($urandom_range(6, 0));
        if (roll >= 92) begin
            // noise: nothing lines up with the current magic
            f.magic     = $urandom;
            f.ext_field = $urandom;
            f.pay_field = $urandom;
            f.n_pay     = 8'd4;
        end else if (roll >= 86) begin
            if ($urandom_range(1, 0)) begin
                f.ext_field = '0;
                f.n_ext     = '0;
            end else begin
                f.pay_field = '0;
                f.n_pay     = '0;
            end
        end else if (roll >= 78) begin
            if ($urandom_range(1, 0)) f.pay_field = $urandom | 32'h100;
            f.cut = 16'($urandom_range(300, 1));
        end else if (roll >= 70) begin
            f.ext_field = $urandom_range(1, 0) ? $urandom_range(7, 5) : ($urandom | 32'h8);
        end else if (roll >= 60) begin
            f.magic = f.magic ^ (32'h1 << $urandom_range(8 * nm - 1, 0));
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [31:0] chars, input logic [2:0] len);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MAGIC_CHARS;
        i_cfg_data <= chars;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MAGIC_LEN;
        i_cfg_data <= {29'd0, len};
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        magic_word = chars;
        magic_sel  = len;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_cnt < MAX_PRINTS)
            $display("result %0d: %s got %0h, want %0h", res_seen, what, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("no request pending, out_byte", 32'(m_tdata), 32'd0);
            end else begin
                want_res = decoded_q.pop_front();
                if (m_tdata !== want_res.out_byte)
                    report_mismatch("out_byte", 32'(m_tdata), 32'(want_res.out_byte));
                if (m_tuser !== want_res.kind)
                    report_mismatch("kind", 32'(m_tuser), 32'(want_res.kind));
                if (m_tlast !== want_res.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want_res.last));
            end
            res_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL lsb_stego_payload_extractor_unit");
            $finish;
        end
    end

    // receiver side; a hold request keeps tready low long enough to back up the queue
    initial begin : rx_side
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (n = 1; n < HOLD_CYCLES; n++) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
            end
        end
    end

    initial begin : stimulus
        t_file f;
        int    row;
        int    p;
        int    due0;
        int    act0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_MAGIC_CHARS;
        i_cfg_data   = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b0;
        magic_word   = '0;
        magic_sel    = 3'd2;
        restart_parse();

        // wr, chars, len, magic, #m, ext, #e, pay, #p, tail, cut, fixed, kind
        dir_tab = '{
            // reset config: magic 00 00, nothing hidden
            '{1'b0, 32'h0, 3'd0, 32'h0000_0000, 2, 32'd0, 0, 32'd0, 0, 4, 0,
              1'b1, KIND_EMPTY},
            '{1'b0, 32'h0, 3'd0, 32'h0000_0000, 2, 32'd3, 3, 32'd5, 5, 3, 0,
              1'b0, KIND_EXT_CHAR},
            // second magic char off
            '{1'b0, 32'h0, 3'd0, 32'h0000_0100, 2, 32'd1, 1, 32'd2, 2, 0, 0,
              1'b1, KIND_MAGIC_ERR},
            '{1'b1, 32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF, 4, 32'd4, 4, 32'd3, 3, 2, 0,
              1'b0, KIND_EXT_CHAR},
            // last of four magic chars off
            '{1'b0, 32'h0, 3'd0, 32'h7FFF_FFFF, 4, 32'd0, 0, 32'd1, 1, 0, 0,
              1'b1, KIND_MAGIC_ERR},
            '{1'b0, 32'h0, 3'd0, 32'hFFFF_FFFF, 4, 32'd5, 0, 32'd1, 1, 0, 0,
              1'b1, KIND_EXT_LONG},
            '{1'b0, 32'h0, 3'd0, 32'hFFFF_FFFF, 4, 32'hFFFF_FFFF, 0, 32'd1, 1, 0, 0,
              1'b1, KIND_EXT_LONG},
            // magic_len 0 checks one char
            '{1'b1, 32'h5A3C_81E7, 3'd0, 32'h5A3C_81E7, 1, 32'd0, 0, 32'd1, 1, 2, 0,
              1'b0, KIND_EXT_CHAR},
            // magic_len 7 checks four; huge size cut off by the next file start
            '{1'b1, 32'h5A3C_81E7, 3'd7, 32'h5A3C_81E7, 4, 32'd2, 2, 32'hFFFF_FFFF, 6, 0, 0,
              1'b0, KIND_EXT_CHAR},
            // cut inside the header, then inside the magic
            '{1'b0, 32'h0, 3'd0, 32'h5A3C_81E7, 4, 32'd0, 0, 32'd1, 1, 0, 20,
              1'b0, KIND_EXT_CHAR},
            '{1'b0, 32'h0, 3'd0, 32'h5A3C_81E7, 4, 32'd0, 0, 32'd1, 1, 0, 70,
              1'b0, KIND_EXT_CHAR},
            '{1'b1, 32'h5A3C_81E7, 3'd1, 32'h5A3C_81E7, 1, 32'd0, 0, 32'd0, 0, 5, 0,
              1'b1, KIND_EMPTY},
            '{1'b1, 32'h00A5_5AC3, 3'd5, 32'h00A5_5AC3, 4, 32'd1, 1, 32'd2, 2, 10, 0,
              1'b0, KIND_EXT_CHAR},
            // full extension, then empty payload
            '{1'b0, 32'h0, 3'd0, 32'h00A5_5AC3, 4, 32'd4, 4, 32'd0, 0, 3, 0,
              1'b0, KIND_EXT_CHAR}
        };

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIR_ROWS; row++) begin
            if (dir_tab[row].wr_cfg) begin
                settle();
                write_cfg(dir_tab[row].cfg_chars, dir_tab[row].cfg_len);
            end
            send_file(dir_tab[row]);
        end

        for (p = 1; p <= 4; p++) begin
            settle();
            case (p)
                1: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    write_cfg(32'h0000_0000, 3'd3);
                end
                2: begin
                    tx_idle_pct  = 67;
                    rx_stall_pct = 0;
                    write_cfg($urandom, 3'd4);
                end
                3: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 67;
                    write_cfg($urandom, 3'd1);
                end
                default: begin
                    tx_idle_pct  = 29;
                    rx_stall_pct = 29;
                    write_cfg($urandom, 3'($urandom_range(7, 0)));
                end
            endcase
            if (p == 1) begin
                // long payload while the receiver holds off
                rand_file(f);
                f.magic     = magic_word;
                f.ext_field = 32'd0;
                f.n_ext     = '0;
                f.pay_field = 32'd48;
                f.n_pay     = 8'd48;
                f.cut       = '0;
                hold_req    = 1'b1;
                send_file(f);
            end
            due0 = decoded_cnt;
            act0 = lsb_bytes;
            while (lsb_bytes - act0 < 260 || decoded_cnt - due0 < 18) begin
                rand_file(f);
                send_file(f);
            end
        end

        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("PASS lsb_stego_payload_extractor_unit");
        else
            $display("FAIL lsb_stego_payload_extractor_unit");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lspe_pkg.sv
rtl/lspe_parse.sv
rtl/lspe_fifo.sv
rtl/lspe_out.sv
rtl/lsb_stego_payload_extractor_unit.sv
sim/tb.sv
